>>> src/refcounted_generational_handle_pool_assert.svh
// Assertion macros for the handle pool checker.
`ifndef REFCOUNTED_GENERATIONAL_HANDLE_POOL_ASSERT_SVH
`define REFCOUNTED_GENERATIONAL_HANDLE_POOL_ASSERT_SVH

`define RGHP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("handle pool check failed");

`define RGHP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("handle pool check failed");

`endif

>>> src/rghp_pkg.sv
package rghp_pkg;

    localparam int SLOTS_DEF        = 64;
    localparam int GEN_BITS_DEF     = 16;
    localparam int PAYLOAD_BITS_DEF = 32;
    localparam int REFS_BITS        = 16;

    typedef enum logic [2:0] {
        OP_ACQUIRE = 3'd0,
        OP_GET     = 3'd1,
        OP_ADDREF  = 3'd2,
        OP_RELEASE = 3'd3,
        OP_CLEAR   = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        ST_DONE    = 3'd0,
        ST_CREATED = 3'd1,
        ST_INVALID = 3'd2,
        ST_FULL    = 3'd3,
        ST_FREED   = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        FSM_IDLE   = 2'd0,
        FSM_LOOKUP = 2'd1,
        FSM_UPDATE = 2'd2
    } t_fsm;

    typedef struct packed {
        logic [2:0]  op;
        logic [63:0] lookup_key;
        logic [31:0] new_payload;
        logic        handle_null;
        logic [5:0]  handle_index;
        logic [15:0] handle_generation;
    } t_in_word;

    typedef struct packed {
        logic [2:0]  status;
        logic [5:0]  out_index;
        logic [15:0] out_generation;
        logic [31:0] out_payload;
        logic [15:0] out_refs;
    } t_out_word;

    // Broadcast command from the controller to every cell.
    typedef struct packed {
        logic        wr;       // write target cell
        logic        clear;    // clear pool
        logic        inc;
        logic        dec;
        logic        alloc;
    } t_cell_cmd;

endpackage

>>> src/rghp_cell.sv
module rghp_cell #(
    parameter int GEN_BITS     = rghp_pkg::GEN_BITS_DEF,
    parameter int PAYLOAD_BITS = rghp_pkg::PAYLOAD_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_sel,
    input  logic                            i_used,
    input  rghp_pkg::t_cell_cmd             i_cmd,
    input  logic [63:0]                     i_key,
    input  logic [PAYLOAD_BITS-1:0]         i_payload,
    input  logic                            i_hit_in,
    output logic                            o_hit_out,
    output logic                            o_match,
    output logic [GEN_BITS-1:0]             o_gen,
    output logic [PAYLOAD_BITS-1:0]         o_payload,
    output logic [rghp_pkg::REFS_BITS-1:0]  o_refs
);

    localparam int RB = rghp_pkg::REFS_BITS;

    logic [63:0]           r_key;
    logic [PAYLOAD_BITS-1:0] r_payload;
    logic [RB-1:0]         r_refs;
    logic [GEN_BITS-1:0]   r_gen;
    logic                  w_live;

    assign w_live    = i_used && (r_refs != '0);
    assign o_match   = w_live && (r_key == i_key) && !i_hit_in;
    assign o_hit_out = i_hit_in || (w_live && (r_key == i_key));
    assign o_gen     = r_gen;
    assign o_payload = r_payload;
    assign o_refs    = r_refs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_payload <= '0;
            r_refs    <= '0;
            r_gen     <= '0;
        end else if (i_cmd.clear) begin
            if (i_used) begin
                r_gen     <= r_gen + 1'b1;
                r_payload <= '0;
                r_refs    <= '0;
            end
        end else if (i_cmd.wr && i_sel) begin
            if (i_cmd.alloc) begin
                r_key     <= i_key;
                r_payload <= i_payload;
                r_refs    <= RB'(1);
            end else if (i_cmd.inc) begin
                if (r_refs != {RB{1'b1}}) begin
                    r_refs <= r_refs + 1'b1;
                end
            end else if (i_cmd.dec) begin
                r_refs <= r_refs - 1'b1;
                if (r_refs == RB'(1)) begin
                    r_gen     <= r_gen + 1'b1;
                    r_payload <= '0;
                end
            end
        end
    end

endmodule

>>> src/rghp_ctrl.sv
module rghp_ctrl #(
    parameter int SLOTS        = rghp_pkg::SLOTS_DEF,
    parameter int GEN_BITS     = rghp_pkg::GEN_BITS_DEF,
    parameter int PAYLOAD_BITS = rghp_pkg::PAYLOAD_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  rghp_pkg::t_in_word            i_word,
    input  logic                          i_hit,
    input  logic [$clog2(SLOTS)-1:0]      i_hit_idx,
    input  logic [GEN_BITS-1:0]           i_sel_gen,
    input  logic [PAYLOAD_BITS-1:0]       i_sel_payload,
    input  logic [rghp_pkg::REFS_BITS-1:0] i_sel_refs,
    output logic                          o_busy,
    output rghp_pkg::t_in_word            o_word,
    output logic [$clog2(SLOTS)-1:0]      o_target,
    output logic [$clog2(SLOTS):0]        o_used_mark,
    output rghp_pkg::t_cell_cmd           o_cmd,
    output logic                          o_valid,
    output rghp_pkg::t_out_word           o_result
);

    localparam int IW = $clog2(SLOTS);
    localparam int RB = rghp_pkg::REFS_BITS;

    rghp_pkg::t_fsm      r_state, n_state;
    rghp_pkg::t_in_word  r_word;
    logic [IW-1:0]       r_target, n_target;
    logic [IW:0]         r_used, n_used;
    logic [IW:0]         r_depth, n_depth;
    logic [2:0]          r_stat, n_stat;
    logic                r_blank, n_blank;
    logic                r_valid, n_valid;
    logic [IW-1:0]       r_stack [SLOTS];
    logic [IW-1:0]       r_pop;
    logic                w_push;
    logic [IW:0]         w_hidx;
    logic                w_hok;
    rghp_pkg::t_op       w_op;

    assign w_op   = rghp_pkg::t_op'(r_word.op);
    assign w_hidx = (IW + 1)'(r_word.handle_index);
    assign w_hok  = !r_word.handle_null && (w_hidx < r_used)
                    && ((IW + 1) >= 7 || r_word.handle_index < 6'(SLOTS))
                    && (16'(i_sel_gen) == r_word.handle_generation)
                    && (i_sel_refs != '0);

    always_ff @(posedge i_clk) begin
        if (r_depth != '0) begin
            r_pop <= r_stack[r_depth[IW-1:0] - 1'b1];
        end
        if (w_push) begin
            r_stack[r_depth[IW-1:0]] <= n_target;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_target = r_target;
        n_used   = r_used;
        n_depth  = r_depth;
        n_stat   = r_stat;
        n_blank  = r_blank;
        n_valid  = 1'b0;
        w_push   = 1'b0;
        o_cmd    = '0;
        case (r_state)
            rghp_pkg::FSM_IDLE: begin
                if (i_start) begin
                    n_state = rghp_pkg::FSM_LOOKUP;
                end
            end
            rghp_pkg::FSM_LOOKUP: begin
                n_state = rghp_pkg::FSM_UPDATE;
                n_blank = 1'b0;
                case (w_op)
                    rghp_pkg::OP_ACQUIRE: begin
                        if (i_hit) begin
                            n_target = i_hit_idx;
                            n_stat   = rghp_pkg::ST_DONE;
                        end else if (r_depth != '0) begin
                            n_target = r_pop;
                            n_depth  = r_depth - 1'b1;
                            n_stat   = rghp_pkg::ST_CREATED;
                        end else if (r_used < (IW + 1)'(SLOTS)) begin
                            n_target = r_used[IW-1:0];
                            n_used   = r_used + 1'b1;
                            n_stat   = rghp_pkg::ST_CREATED;
                        end else begin
                            n_stat  = rghp_pkg::ST_FULL;
                            n_blank = 1'b1;
                        end
                    end
                    rghp_pkg::OP_GET, rghp_pkg::OP_ADDREF, rghp_pkg::OP_RELEASE: begin
                        n_target = r_word.handle_index[IW-1:0];
                        if (!w_hok) begin
                            n_stat  = rghp_pkg::ST_INVALID;
                            n_blank = 1'b1;
                        end else if (w_op == rghp_pkg::OP_RELEASE && i_sel_refs == RB'(1)) begin
                            n_stat = rghp_pkg::ST_FREED;
                        end else begin
                            n_stat = rghp_pkg::ST_DONE;
                        end
                    end
                    rghp_pkg::OP_CLEAR: begin
                        n_stat  = rghp_pkg::ST_DONE;
                        n_blank = 1'b1;
                        n_depth = '0;
                        n_used  = '0;
                        o_cmd.clear = 1'b1;
                    end
                    default: begin
                        n_stat  = rghp_pkg::ST_INVALID;
                        n_blank = 1'b1;
                    end
                endcase
                if (!n_blank) begin
                    o_cmd.wr    = 1'b1;
                    o_cmd.alloc = (w_op == rghp_pkg::OP_ACQUIRE) && !i_hit;
                    o_cmd.inc   = (w_op == rghp_pkg::OP_ACQUIRE && i_hit)
                                  || (w_op == rghp_pkg::OP_ADDREF);
                    o_cmd.dec   = (w_op == rghp_pkg::OP_RELEASE);
                end
                if (!n_blank && w_op == rghp_pkg::OP_RELEASE && i_sel_refs == RB'(1)) begin
                    w_push = 1'b1;
                    n_depth = r_depth + 1'b1;
                end
            end
            rghp_pkg::FSM_UPDATE: begin
                n_valid = 1'b1;
                n_state = rghp_pkg::FSM_IDLE;
            end
            default: begin
                n_state = rghp_pkg::FSM_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rghp_pkg::FSM_IDLE;
            r_used  <= '0;
            r_depth <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
            r_depth <= n_depth;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == rghp_pkg::FSM_IDLE && i_start) begin
            r_word <= i_word;
        end
        r_target <= n_target;
        r_stat   <= n_stat;
        r_blank  <= n_blank;
    end

    assign o_busy      = (r_state != rghp_pkg::FSM_IDLE);
    assign o_word      = r_word;
    assign o_target    = (r_state == rghp_pkg::FSM_LOOKUP) ? n_target : r_target;
    assign o_used_mark = r_used;
    assign o_valid     = r_valid;

    always_comb begin
        o_result        = '0;
        o_result.status = r_stat;
        if (!r_blank) begin
            o_result.out_index      = 6'(r_target);
            o_result.out_generation = 16'(i_sel_gen);
            o_result.out_payload    = 32'(i_sel_payload);
            o_result.out_refs       = i_sel_refs;
        end
    end

endmodule

>>> src/refcounted_generational_handle_pool.sv
// An accepted word is registered and the FSM enters LOOKUP, where lookup and slot write happen;
// UPDATE then sets the valid register, and the result shows while the FSM is back in IDLE.
// Busy holds from acceptance until the result shows, so a new word can be taken as it shows.
// The key compare resolves lowest-index hit through the cell chain's hit-forward path.
// Reset clears counts, payloads, generations, free stack depth and used mark at once.
// Results show for one cycle with o_valid; the receiver cannot stall.
module refcounted_generational_handle_pool #(
    parameter int SLOTS        = rghp_pkg::SLOTS_DEF,
    parameter int GEN_BITS     = rghp_pkg::GEN_BITS_DEF,
    parameter int PAYLOAD_BITS = rghp_pkg::PAYLOAD_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  rghp_pkg::t_in_word   i_word,
    output logic                 o_valid,
    output rghp_pkg::t_out_word  o_result
);

    localparam int IW = $clog2(SLOTS);
    localparam int RB = rghp_pkg::REFS_BITS;

    rghp_pkg::t_in_word   w_word;
    rghp_pkg::t_cell_cmd  w_cmd;
    logic [IW-1:0]        w_target;
    logic [IW:0]          w_used;
    logic [SLOTS:0]       w_chain;
    logic [SLOTS-1:0]     w_match;
    logic [GEN_BITS-1:0]  w_gen [SLOTS];
    logic [PAYLOAD_BITS-1:0] w_pay [SLOTS];
    logic [RB-1:0]        w_refs [SLOTS];
    logic [IW-1:0]        w_hit_idx;

    assign w_chain[0] = 1'b0;

    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        rghp_cell #(
            .GEN_BITS     (GEN_BITS),
            .PAYLOAD_BITS (PAYLOAD_BITS)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_sel     (w_target == IW'(g)),
            .i_used    ((IW + 1)'(g) < w_used),
            .i_cmd     (w_cmd),
            .i_key     (w_word.lookup_key),
            .i_payload (PAYLOAD_BITS'(w_word.new_payload)),
            .i_hit_in  (w_chain[g]),
            .o_hit_out (w_chain[g+1]),
            .o_match   (w_match[g]),
            .o_gen     (w_gen[g]),
            .o_payload (w_pay[g]),
            .o_refs    (w_refs[g])
        );
    end

    always_comb begin
        w_hit_idx = '0;
        for (int k = 0; k < SLOTS; k++) begin
            if (w_match[k]) begin
                w_hit_idx = w_hit_idx | IW'(k);
            end
        end
    end

    rghp_ctrl #(
        .SLOTS        (SLOTS),
        .GEN_BITS     (GEN_BITS),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_word        (i_word),
        .i_hit         (w_chain[SLOTS]),
        .i_hit_idx     (w_hit_idx),
        .i_sel_gen     (w_gen[w_target]),
        .i_sel_payload (w_pay[w_target]),
        .i_sel_refs    (w_refs[w_target]),
        .o_busy        (busy),
        .o_word        (w_word),
        .o_target      (w_target),
        .o_used_mark   (w_used),
        .o_cmd         (w_cmd),
        .o_valid       (o_valid),
        .o_result      (o_result)
    );

endmodule

>>> src/rghp_checker.sv
`include "refcounted_generational_handle_pool_assert.svh"

module rghp_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    input  logic                 busy,
    input  logic                 o_valid,
    input  rghp_pkg::t_out_word  o_result
);

    `RGHP_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, start && !busy, busy)
    `RGHP_ASSERT_IMPL(a_valid_idle, i_clk, i_rst_n, o_valid, !busy)
    `RGHP_ASSERT_NEXT(a_valid_pulse, i_clk, i_rst_n, o_valid, !o_valid)
    `RGHP_ASSERT_IMPL(a_status_range, i_clk, i_rst_n, o_valid, o_result.status <= rghp_pkg::ST_FREED)
    `RGHP_ASSERT_IMPL(a_blank_fail, i_clk, i_rst_n, o_valid && (o_result.status == rghp_pkg::ST_INVALID || o_result.status == rghp_pkg::ST_FULL), o_result.out_refs == '0 && o_result.out_payload == '0)

endmodule

bind refcounted_generational_handle_pool rghp_checker u_rghp_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_valid  (o_valid),
    .o_result (o_result)
);

>>> tb/sv/refcounted_generational_handle_pool_checker.sv
module refcounted_generational_handle_pool_checker
    import rghp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    input  logic       busy,
    input  t_in_word   i_word,
    input  logic       o_valid,
    input  t_out_word  o_result,
    output int         o_fail_count,
    output int         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  POOL_SLOTS = SLOTS_DEF;
    localparam logic [15:0] REFS_CAP = 16'hFFFF;

    logic [63:0] key_tbl   [POOL_SLOTS];
    logic [31:0] pay_tbl   [POOL_SLOTS];
    logic [15:0] refs_tbl  [POOL_SLOTS];
    logic [15:0] gen_tbl   [POOL_SLOTS];
    logic [5:0]  free_lifo [POOL_SLOTS];
    int          free_top;
    int          high_water;
    t_out_word   expected_words[$];
    int          fail_count;

    assign o_fail_count = fail_count;
    assign o_pending    = expected_words.size();

    function automatic t_out_word slot_word(t_status st, int idx);
        t_out_word r;
        r.status         = st;
        r.out_index      = idx[5:0];
        r.out_generation = gen_tbl[idx];
        r.out_payload    = pay_tbl[idx];
        r.out_refs       = refs_tbl[idx];
        return r;
    endfunction

    function automatic t_out_word pool_apply(t_in_word w);
        t_out_word r;
        int        idx;
        r = '0;
        case (w.op)
            OP_ACQUIRE: begin
                for (int i = 0; i < high_water; i++) begin
                    if (refs_tbl[i] != 0 && key_tbl[i] == w.lookup_key) begin
                        if (refs_tbl[i] < REFS_CAP) refs_tbl[i]++;
                        return slot_word(ST_DONE, i);
                    end
                end
                if (free_top > 0) begin
                    free_top--;
                    idx = free_lifo[free_top];
                end else if (high_water < POOL_SLOTS) begin
                    idx = high_water;
                    high_water++;
                end else begin
                    r.status = ST_FULL;
                    return r;
                end
                key_tbl[idx]  = w.lookup_key;
                pay_tbl[idx]  = w.new_payload;
                refs_tbl[idx] = 16'd1;
                return slot_word(ST_CREATED, idx);
            end
            OP_GET, OP_ADDREF, OP_RELEASE: begin
                idx = w.handle_index;
                if (w.handle_null || idx >= high_water || gen_tbl[idx] != w.handle_generation
                        || refs_tbl[idx] == 0) begin
                    r.status = ST_INVALID;
                    return r;
                end
                if (w.op == OP_GET) return slot_word(ST_DONE, idx);
                if (w.op == OP_ADDREF) begin
                    if (refs_tbl[idx] < REFS_CAP) refs_tbl[idx]++;
                    return slot_word(ST_DONE, idx);
                end
                refs_tbl[idx]--;
                if (refs_tbl[idx] != 0) return slot_word(ST_DONE, idx);
                gen_tbl[idx]++;
                pay_tbl[idx] = '0;
                if (free_top < POOL_SLOTS) begin
                    free_lifo[free_top] = idx[5:0];
                    free_top++;
                end
                return slot_word(ST_FREED, idx);
            end
            OP_CLEAR: begin
                for (int i = 0; i < high_water; i++) begin
                    gen_tbl[i]++;
                    pay_tbl[i]  = '0;
                    refs_tbl[i] = '0;
                end
                free_top   = 0;
                high_water = 0;
                r.status   = ST_DONE;
                return r;
            end
            default: begin
                r.status = ST_INVALID;
                return r;
            end
        endcase
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("%0t: mismatch on %s: got %0h, want %0h", $time, what, got, want);
        fail_count++;
    endtask

    initial begin
        fail_count = 0;
        free_top   = 0;
        high_water = 0;
        for (int i = 0; i < POOL_SLOTS; i++) begin
            pay_tbl[i]  = '0;
            refs_tbl[i] = '0;
            gen_tbl[i]  = '0;
        end
    end

    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n && o_valid) begin
            if (expected_words.size() == 0) begin
                report_mismatch("unexpected word", 64'(o_result.status), 64'(0));
            end else begin
                want = expected_words.pop_front();
                if (o_result.status != want.status)
                    report_mismatch("status", 64'(o_result.status), 64'(want.status));
                if (o_result.out_index != want.out_index)
                    report_mismatch("out_index", 64'(o_result.out_index),
                                    64'(want.out_index));
                if (o_result.out_generation != want.out_generation)
                    report_mismatch("out_generation", 64'(o_result.out_generation),
                                    64'(want.out_generation));
                if (o_result.out_payload != want.out_payload)
                    report_mismatch("out_payload", 64'(o_result.out_payload),
                                    64'(want.out_payload));
                if (o_result.out_refs != want.out_refs)
                    report_mismatch("out_refs", 64'(o_result.out_refs), 64'(want.out_refs));
            end
        end
        if (i_rst_n && start && !busy) expected_words = {expected_words, pool_apply(i_word)};
    end

    final begin
        if (expected_words.size() != 0)
            $display("%0d words still expected", expected_words.size());
    end
endmodule

>>> tb/sv/refcounted_generational_handle_pool_tb.sv
module refcounted_generational_handle_pool_tb;
    import rghp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] OP_SPARE_LO  = 3'd5;
    localparam logic [2:0] OP_SPARE_MID = 3'd6;
    localparam logic [2:0] OP_SPARE_HI  = 3'd7;
    localparam int         STALL_LIMIT  = 2000;

    logic      i_clk;
    logic      i_rst_n;
    logic      start;
    logic      busy;
    t_in_word  i_word;
    logic      o_valid;
    t_out_word o_result;
    int        fail_count;
    int        pending;
    int        idle_cycles;
    int        word_count;
    int        full_seen;
    int        freed_seen;
    logic        live_ok  [64];
    logic [15:0] live_gen [64];
    logic [63:0] key_set  [16];

    refcounted_generational_handle_pool dut (
        .i_clk, .i_rst_n, .start, .busy, .i_word, .o_valid, .o_result
    );

    refcounted_generational_handle_pool_checker checker_i (
        .i_clk, .i_rst_n, .start, .busy, .i_word, .o_valid, .o_result,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (i_rst_n && o_valid) begin
            if (o_result.status == ST_FULL) full_seen <= full_seen + 1;
            if (o_result.status == ST_FREED) begin
                freed_seen <= freed_seen + 1;
                live_ok[o_result.out_index] <= 1'b0;
            end else if ((o_result.status == ST_DONE || o_result.status == ST_CREATED)
                         && o_result.out_refs != 0) begin
                live_ok[o_result.out_index]  <= 1'b1;
                live_gen[o_result.out_index] <= o_result.out_generation;
            end else if (o_result.status == ST_DONE) begin
                for (int i = 0; i < 64; i++) live_ok[i] <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", idle_cycles);
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic send_word(t_in_word w, int gap);
        @(negedge i_clk);
        if (gap > 0) begin
            start = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
            @(negedge i_clk);
        end
        start  = 1'b1;
        i_word = w;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        word_count++;
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        start = 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    function automatic t_in_word make_word(logic [2:0] op, logic [63:0] key, logic [31:0] pay,
                                           logic hnull, logic [5:0] idx, logic [15:0] gen);
        t_in_word w;
        w.op                = op;
        w.lookup_key        = key;
        w.new_payload       = pay;
        w.handle_null       = hnull;
        w.handle_index      = idx;
        w.handle_generation = gen;
        return w;
    endfunction

    function automatic t_in_word noise_word(logic [2:0] op);
        return make_word(op, {$urandom, $urandom}, $urandom, 1'($urandom_range(0, 1)),
                         6'($urandom_range(0, 63)), 16'($urandom_range(0, 65535)));
    endfunction

    function automatic t_in_word handle_word(logic [2:0] op);
        int picks[$];
        int idx;
        for (int i = 0; i < 64; i++) if (live_ok[i]) picks = {picks, i};
        if (picks.size() == 0 || $urandom_range(0, 9) < 2) return noise_word(op);
        idx = picks[$urandom_range(0, picks.size() - 1)];
        return make_word(op, {$urandom, $urandom}, $urandom, 1'b0, idx[5:0],
                         ($urandom_range(0, 19) == 0) ? 16'(live_gen[idx] + 16'd1)
                                                      : live_gen[idx]);
    endfunction

    function automatic t_in_word random_word();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 38)
            return make_word(OP_ACQUIRE,
                             ($urandom_range(0, 9) < 8) ? key_set[$urandom_range(0, 15)]
                                                        : {$urandom, $urandom},
                             $urandom, 1'($urandom_range(0, 1)), 6'($urandom_range(0, 63)),
                             16'($urandom_range(0, 65535)));
        if (sel < 55) return handle_word(OP_GET);
        if (sel < 70) return handle_word(OP_ADDREF);
        if (sel < 95) return handle_word(OP_RELEASE);
        if (sel < 97) return noise_word(OP_CLEAR);
        return noise_word(3'($urandom_range(int'(OP_SPARE_LO), int'(OP_SPARE_HI))));
    endfunction

    initial begin
        int gap;
        start       = 1'b0;
        i_word      = '0;
        i_rst_n     = 1'b0;
        word_count  = 0;
        full_seen   = 0;
        freed_seen  = 0;
        for (int i = 0; i < 64; i++) begin
            live_ok[i]  = 1'b0;
            live_gen[i] = '0;
        end
        for (int i = 0; i < 16; i++) key_set[i] = {$urandom, $urandom};
        key_set[0] = '0;
        key_set[1] = '1;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_word(make_word(OP_GET, '0, '0, 1'b0, 6'd0, 16'd0), 0);
        send_word(make_word(OP_ACQUIRE, '0, '1, 1'b1, 6'd63, 16'hFFFF), 0);
        send_word(make_word(OP_ACQUIRE, '1, '0, 1'b0, 6'd0, 16'd0), 1);
        send_word(make_word(OP_ACQUIRE, '0, 32'h1234, 1'b0, 6'd0, 16'd0), 0);
        send_word(make_word(OP_GET, '0, '0, 1'b0, 6'd1, 16'd0), 2);
        send_word(make_word(OP_GET, '0, '0, 1'b1, 6'd0, 16'd0), 0);
        send_word(make_word(OP_GET, '0, '0, 1'b0, 6'd0, 16'd1), 0);
        send_word(make_word(OP_GET, '0, '0, 1'b0, 6'd63, 16'd0), 0);
        send_word(make_word(OP_ADDREF, '1, '1, 1'b0, 6'd0, 16'd0), 0);
        send_word(make_word(OP_RELEASE, '0, '0, 1'b0, 6'd0, 16'd0), 3);
        send_word(make_word(OP_RELEASE, '0, '0, 1'b0, 6'd0, 16'd0), 0);
        send_word(make_word(OP_RELEASE, '0, '0, 1'b0, 6'd0, 16'd0), 0);
        send_word(make_word(OP_RELEASE, '0, '0, 1'b0, 6'd0, 16'd0), 0);
        send_word(make_word(OP_ACQUIRE, 64'h5A5A, 32'h77, 1'b0, 6'd0, 16'd0), 0);
        send_word(make_word(OP_RELEASE, '0, '0, 1'b0, 6'd1, 16'd0), 0);
        send_word(make_word(OP_ACQUIRE, 64'hA5A5, 32'h88, 1'b0, 6'd0, 16'd0), 0);
        send_word(make_word(OP_ACQUIRE, 64'hC3C3, 32'h99, 1'b0, 6'd0, 16'd0), 0);
        send_word(make_word(OP_SPARE_LO, '1, '1, 1'b0, 6'd0, 16'd1), 0);
        send_word(make_word(OP_SPARE_HI, '1, '1, 1'b1, 6'd63, 16'hFFFF), 0);
        send_word(make_word(OP_SPARE_MID, '0, '0, 1'b0, 6'd0, 16'd0), 0);
        send_word(make_word(OP_CLEAR, '0, '0, 1'b0, 6'd0, 16'd0), 0);
        send_word(make_word(OP_GET, '0, '0, 1'b0, 6'd0, 16'd1), 0);
        drain_results();

        for (int n = 0; n < 460; n++) begin
            if (n == 200) begin
                drain_results();
                send_word(noise_word(OP_CLEAR), 0);
                for (int k = 0; k < 66; k++)
                    send_word(make_word(OP_ACQUIRE, {$urandom, $urandom}, $urandom, 1'b0,
                                        6'd0, 16'd0), $urandom_range(0, 6));
                drain_results();
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
            if ((n / 40) % 3 == 1) gap = 0;
            send_word(random_word(), gap);
        end
        drain_results();
        repeat (10) @(posedge i_clk);

        $display("Sent %0d words: %0d slots freed, %0d pool-full results,", word_count,
                 freed_seen, full_seen);
        $display("mixed lookups, handle checks, stale handles, clears and spare op codes");
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
